@@ sv/rfag_pkg.sv @@
`default_nettype none

package rfag_pkg;

  localparam int CoordW   = 13;
  localparam int DimW     = 13;
  localparam int OrgW     = 12;
  localparam int PosW     = 14;
  localparam int CalcW    = 15;
  localparam int ColorW   = 16;
  localparam int OffW     = 26;
  localparam int ScreenW  = 13;
  localparam int LineW    = 15;
  localparam int PixBitsW = 6;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 15;

  // bits per byte is 2**ByteShift
  localparam int ByteShift = 3;
  localparam int RowProdW  = PosW + LineW;
  localparam int ColProdW  = PosW + PixBitsW;

  localparam int InFieldsW = 4 * CoordW + ColorW;
  localparam int InDataW   = ((InFieldsW + 7) / 8) * 8;
  localparam int OutFieldsW = OffW + ColorW;
  localparam int OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  typedef enum logic {
    OpStart = 1'b0,
    OpTick  = 1'b1
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgScreenCols = 2'd0,
    CfgScreenRows = 2'd1,
    CfgLineBytes  = 2'd2,
    CfgPixelBits  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [ScreenW-1:0]  screen_columns;
    logic [ScreenW-1:0]  screen_rows;
    logic [LineW-1:0]    line_bytes;
    logic [PixBitsW-1:0] pixel_bits;
  } cfg_t;

  // one stepped item, coordinates zero when no pixel is written
  typedef struct packed {
    logic              valid;
    logic              last;
    logic              rej;
    logic [PosW-1:0]   col;
    logic [PosW-1:0]   row;
    logic [ColorW-1:0] color;
  } pix_t;

endpackage

`default_nettype wire

@@ sv/rfag_step.sv @@
`default_nettype none

module rfag_step (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire rfag_pkg::cfg_t                 cfg_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           opcode_i,
  input  wire logic [rfag_pkg::CoordW-1:0]    corner_x_i,
  input  wire logic [rfag_pkg::CoordW-1:0]    corner_y_i,
  input  wire logic [rfag_pkg::DimW-1:0]      rect_width_i,
  input  wire logic [rfag_pkg::DimW-1:0]      rect_height_i,
  input  wire logic [rfag_pkg::ColorW-1:0]    fill_color_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output rfag_pkg::pix_t                      pix_o
);

  localparam int CalcW = rfag_pkg::CalcW;

  logic                          busy_q, busy_d;
  logic [rfag_pkg::OrgW-1:0]     org_col_q, org_col_d;
  logic [rfag_pkg::OrgW-1:0]     org_row_q, org_row_d;
  logic [rfag_pkg::DimW-1:0]     span_cols_q, span_cols_d;
  logic [rfag_pkg::DimW-1:0]     span_rows_q, span_rows_d;
  logic [rfag_pkg::DimW-1:0]     step_col_q, step_col_d;
  logic [rfag_pkg::DimW-1:0]     step_row_q, step_row_d;
  logic [rfag_pkg::ColorW-1:0]   color_q, color_d;
  logic                          s1_v_q, s1_v_d;
  rfag_pkg::pix_t                pix_q, pix_d;

  logic                          acc;
  logic signed [CalcW-1:0]       x_in, y_in, x_pos, y_pos, x_lim, y_lim, w_s, h_s, x_cl, y_cl;
  logic [rfag_pkg::DimW-1:0]     col_inc, row_inc;

  assign in_ready_o = !s1_v_q || out_ready_i;
  assign acc        = in_valid_i && in_ready_o;

  // corner clamp
  always_comb begin
    x_in  = CalcW'($signed(corner_x_i));
    y_in  = CalcW'($signed(corner_y_i));
    w_s   = $signed({2'b00, rect_width_i});
    h_s   = $signed({2'b00, rect_height_i});
    x_pos = x_in[CalcW-1] ? '0 : x_in;
    y_pos = y_in[CalcW-1] ? '0 : y_in;
    x_lim = $signed({2'b00, cfg_i.screen_columns}) - CalcW'(1);
    y_lim = $signed({2'b00, cfg_i.screen_rows}) - CalcW'(1);
    x_cl  = (x_pos + w_s > x_lim) ? x_lim - w_s : x_pos;
    y_cl  = (y_pos + h_s > y_lim) ? y_lim - h_s : y_pos;
  end

  assign col_inc = step_col_q + rfag_pkg::DimW'(1);
  assign row_inc = step_row_q + rfag_pkg::DimW'(1);

  always_comb begin
    busy_d      = busy_q;
    org_col_d   = org_col_q;
    org_row_d   = org_row_q;
    span_cols_d = span_cols_q;
    span_rows_d = span_rows_q;
    step_col_d  = step_col_q;
    step_row_d  = step_row_q;
    color_d     = color_q;
    pix_d       = '0;
    if (acc) begin
      unique case (rfag_pkg::opcode_e'(opcode_i))
        rfag_pkg::OpStart: begin
          busy_d = 1'b0;
          if (x_cl[CalcW-1] || y_cl[CalcW-1]) begin
            pix_d.rej = 1'b1;
          end else begin
            org_col_d   = x_cl[rfag_pkg::OrgW-1:0];
            org_row_d   = y_cl[rfag_pkg::OrgW-1:0];
            span_cols_d = rect_width_i;
            span_rows_d = rect_height_i;
            step_col_d  = '0;
            step_row_d  = '0;
            color_d     = fill_color_i;
            busy_d      = (rect_width_i != '0) && (rect_height_i != '0);
          end
        end
        rfag_pkg::OpTick: begin
          if (busy_q) begin
            pix_d.valid = 1'b1;
            pix_d.col   = {2'b00, org_col_q} + {1'b0, step_col_q};
            pix_d.row   = {2'b00, org_row_q} + {1'b0, step_row_q};
            pix_d.color = color_q;
            step_col_d  = col_inc;
            if (col_inc >= span_cols_q) begin
              step_col_d = '0;
              step_row_d = row_inc;
              if (row_inc >= span_rows_q) begin
                busy_d     = 1'b0;
                pix_d.last = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    s1_v_d = s1_v_q;
    if (in_ready_o) begin
      s1_v_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      org_col_q   <= '0;
      org_row_q   <= '0;
      span_cols_q <= '0;
      span_rows_q <= '0;
      step_col_q  <= '0;
      step_row_q  <= '0;
      color_q     <= '0;
      s1_v_q      <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      org_col_q   <= org_col_d;
      org_row_q   <= org_row_d;
      span_cols_q <= span_cols_d;
      span_rows_q <= span_rows_d;
      step_col_q  <= step_col_d;
      step_row_q  <= step_row_d;
      color_q     <= color_d;
      s1_v_q      <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      pix_q <= pix_d;
    end
  end

  assign out_valid_o = s1_v_q;
  assign pix_o       = pix_q;

  a_last_is_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && pix_q.last) |-> pix_q.valid)
    else $error("last mark on a non-pixel item");

  a_rej_no_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && pix_q.rej) |-> !pix_q.valid && !busy_q)
    else $error("rejected start left a pixel or a busy engine");

  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && opcode_i == rfag_pkg::OpTick && !busy_q) |=> (s1_v_q && pix_q == '0))
    else $error("idle tick produced a nonzero result");

  a_busy_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> ($past(acc && opcode_i == rfag_pkg::OpStart) || pix_q.last))
    else $error("engine went idle without last pixel or new start");

endmodule

`default_nettype wire

@@ sv/rfag_offset.sv @@
`default_nettype none

module rfag_offset (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire rfag_pkg::cfg_t                cfg_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire rfag_pkg::pix_t                pix_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               pixel_valid_o,
  output logic [rfag_pkg::OffW-1:0]          byte_offset_o,
  output logic [rfag_pkg::ColorW-1:0]        pixel_color_o,
  output logic                               last_pixel_o,
  output logic                               rejected_o
);

  localparam int OffW = rfag_pkg::OffW;
  localparam int ColTermW = rfag_pkg::ColProdW - rfag_pkg::ByteShift;

  logic                             out_v_q, out_v_d;
  logic                             acc;
  logic [rfag_pkg::RowProdW-1:0]    row_prod;
  logic [rfag_pkg::ColProdW-1:0]    col_prod;
  logic [OffW-1:0]                  offset_d;
  logic [OffW-1:0]                  offset_q;
  logic [rfag_pkg::ColorW-1:0]      color_q;
  logic                             valid_q, last_q, rej_q;

  assign in_ready_o = !out_v_q || out_ready_i;
  assign acc        = in_valid_i && in_ready_o;

  assign row_prod = rfag_pkg::RowProdW'(pix_i.row) * rfag_pkg::RowProdW'(cfg_i.line_bytes);
  assign col_prod = rfag_pkg::ColProdW'(pix_i.col) * rfag_pkg::ColProdW'(cfg_i.pixel_bits);
  assign offset_d = row_prod[OffW-1:0]
                  + {{(OffW-ColTermW){1'b0}}, col_prod[rfag_pkg::ColProdW-1:rfag_pkg::ByteShift]};

  always_comb begin
    out_v_d = out_v_q;
    if (in_ready_o) begin
      out_v_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      offset_q <= offset_d;
      color_q  <= pix_i.color;
      valid_q  <= pix_i.valid;
      last_q   <= pix_i.last;
      rej_q    <= pix_i.rej;
    end
  end

  assign out_valid_o   = out_v_q;
  assign pixel_valid_o = valid_q;
  assign byte_offset_o = offset_q;
  assign pixel_color_o = color_q;
  assign last_pixel_o  = last_q;
  assign rejected_o    = rej_q;

endmodule

`default_nettype wire

@@ sv/rectangle_fill_address_generator.sv @@
// Rectangle fill address generator. A start (tuser = 0) clamps the corner to
// the screen and arms the engine or, if still negative, is rejected; a tick
// (tuser = 1) to an armed engine gives one pixel write, row by row, left to
// right, with framebuffer byte offset, color and last mark. Each input gives
// exactly one output transfer, one item per clock unless the output stalls,
// via step stage (clamp, row/column counters) then offset stage (row times
// line bytes plus scaled column). Registers must be written through the cfg
// port only while no items are in flight; the block does not enforce this.
`default_nettype none

module rectangle_fill_address_generator (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [rfag_pkg::CfgIdxW-1:0]       cfg_addr_i,
  input  wire logic [rfag_pkg::CfgDataW-1:0]      cfg_data_i,
  input  wire logic                               s_tvalid_i,
  output logic                                    s_tready_o,
  // corner_x, corner_y, rect_width, rect_height, fill_color, zero pad
  input  wire logic [rfag_pkg::InDataW-1:0]       s_tdata_i,
  // opcode
  input  wire logic                               s_tuser_i,
  output logic                                    m_tvalid_o,
  input  wire logic                               m_tready_i,
  // byte_offset, pixel_color, zero pad
  output logic [rfag_pkg::OutDataW-1:0]           m_tdata_o,
  // pixel_valid, rejected
  output logic [1:0]                              m_tuser_o,
  // last_pixel
  output logic                                    m_tlast_o
);

  localparam int CoordW = rfag_pkg::CoordW;
  localparam int ColorW = rfag_pkg::ColorW;
  localparam int OffW   = rfag_pkg::OffW;

  rfag_pkg::cfg_t cfg_q, cfg_d;
  rfag_pkg::pix_t pix;
  logic           s1_valid, s1_ready;
  logic           pixel_valid, last_pixel, rejected;
  logic [OffW-1:0]   byte_offset;
  logic [ColorW-1:0] pixel_color;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (rfag_pkg::cfg_idx_e'(cfg_addr_i))
        rfag_pkg::CfgScreenCols: cfg_d.screen_columns = cfg_data_i[rfag_pkg::ScreenW-1:0];
        rfag_pkg::CfgScreenRows: cfg_d.screen_rows    = cfg_data_i[rfag_pkg::ScreenW-1:0];
        rfag_pkg::CfgLineBytes:  cfg_d.line_bytes     = cfg_data_i[rfag_pkg::LineW-1:0];
        rfag_pkg::CfgPixelBits:  cfg_d.pixel_bits     = cfg_data_i[rfag_pkg::PixBitsW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_columns <= rfag_pkg::ScreenW'(640);
      cfg_q.screen_rows    <= rfag_pkg::ScreenW'(480);
      cfg_q.line_bytes     <= rfag_pkg::LineW'(1280);
      cfg_q.pixel_bits     <= rfag_pkg::PixBitsW'(16);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rfag_step u_step (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (s_tvalid_i),
    .in_ready_o    (s_tready_o),
    .opcode_i      (s_tuser_i),
    .corner_x_i    (s_tdata_i[CoordW-1:0]),
    .corner_y_i    (s_tdata_i[2*CoordW-1:CoordW]),
    .rect_width_i  (s_tdata_i[3*CoordW-1:2*CoordW]),
    .rect_height_i (s_tdata_i[4*CoordW-1:3*CoordW]),
    .fill_color_i  (s_tdata_i[4*CoordW+ColorW-1:4*CoordW]),
    .out_valid_o   (s1_valid),
    .out_ready_i   (s1_ready),
    .pix_o         (pix)
  );

  rfag_offset u_offset (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (s1_valid),
    .in_ready_o    (s1_ready),
    .pix_i         (pix),
    .out_valid_o   (m_tvalid_o),
    .out_ready_i   (m_tready_i),
    .pixel_valid_o (pixel_valid),
    .byte_offset_o (byte_offset),
    .pixel_color_o (pixel_color),
    .last_pixel_o  (last_pixel),
    .rejected_o    (rejected)
  );

  assign m_tdata_o = {{(rfag_pkg::OutDataW-rfag_pkg::OutFieldsW){1'b0}}, pixel_color, byte_offset};
  assign m_tuser_o = {rejected, pixel_valid};
  assign m_tlast_o = last_pixel;

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rfag_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int MaxReports    = 10;
  localparam int BitsPerByte   = 8;

  typedef enum int {
    RxAlways,
    RxRandom,
    RxPattern
  } rx_style_e;

  typedef struct {
    opcode_e                 op;
    bit signed [CoordW-1:0]  corner_x;
    bit signed [CoordW-1:0]  corner_y;
    bit [DimW-1:0]           rect_w;
    bit [DimW-1:0]           rect_h;
    bit [ColorW-1:0]         color;
  } fill_req_t;

  typedef struct {
    logic              pix_valid;
    logic [OffW-1:0]   offset;
    logic [ColorW-1:0] color;
    logic              last;
    logic              rejected;
  } pixel_write_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]  cfg_addr = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                m_tready = 1'b0;
  wire                 cfg_ready;
  wire                 s_tready;
  wire                 m_tvalid;
  wire [OutDataW-1:0]  m_tdata;
  wire [1:0]           m_tuser;
  wire                 m_tlast;

  // engine copy
  cfg_t             regs = '{screen_columns: 640, screen_rows: 480, line_bytes: 1280,
                             pixel_bits: 16};
  bit               eng_busy;
  bit [OrgW-1:0]    org_col, org_row;
  bit [DimW-1:0]    span_cols, span_rows, cur_col, cur_row;
  bit [ColorW-1:0]  held_color;
  pixel_write_t     pending_writes[$];

  int        errors = 0;
  int        quiet_cycles = 0;
  int        burst_left = 0;
  bit        sender_gaps = 1'b0;
  rx_style_e rx_style = RxAlways;
  bit [15:0] rx_pattern = 16'h00ff;
  int        rx_hold = 0;

  rectangle_fill_address_generator dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_addr_i (cfg_addr),
    .cfg_data_i (cfg_data),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata),
    .m_tuser_o  (m_tuser),
    .m_tlast_o  (m_tlast)
  );

  always #4 clk = ~clk;

  function automatic int fit_to_screen(int pos, int size, int screen);
    if (pos < 0) pos = 0;
    if (pos + size > screen - 1) pos = screen - 1 - size;
    return pos;
  endfunction

  function automatic pixel_write_t advance_engine(fill_req_t rq);
    pixel_write_t res;
    int           x, y;
    longint       col, row, off;
    res = '{default: '0};
    if (rq.op == OpStart) begin
      x = fit_to_screen(rq.corner_x, rq.rect_w, regs.screen_columns);
      y = fit_to_screen(rq.corner_y, rq.rect_h, regs.screen_rows);
      eng_busy = 1'b0;
      if (x < 0 || y < 0) begin
        res.rejected = 1'b1;
      end else begin
        org_col    = OrgW'(x);
        org_row    = OrgW'(y);
        span_cols  = rq.rect_w;
        span_rows  = rq.rect_h;
        cur_col    = '0;
        cur_row    = '0;
        held_color = rq.color;
        eng_busy   = rq.rect_w != 0 && rq.rect_h != 0;
      end
    end else if (eng_busy) begin
      col = longint'(org_col) + longint'(cur_col);
      row = longint'(org_row) + longint'(cur_row);
      off = row * longint'(regs.line_bytes) + (col * longint'(regs.pixel_bits)) / BitsPerByte;
      res.pix_valid = 1'b1;
      res.offset    = OffW'(off);
      res.color     = held_color;
      cur_col = cur_col + 1'b1;
      if (cur_col >= span_cols) begin
        cur_col = '0;
        cur_row = cur_row + 1'b1;
        if (cur_row >= span_rows) begin
          eng_busy = 1'b0;
          res.last = 1'b1;
        end
      end
    end
    return res;
  endfunction

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return 4096;
    if (r == 2) return $urandom_range(7, 4095);
    return $urandom_range(1, 6);
  endfunction

  function automatic int pick_corner(int screen);
    int r;
    r = $urandom_range(0, 9);
    if (r <= 5) return $urandom_range(0, screen - 1);
    if (r == 6) return 0 - int'($urandom_range(1, 4096));
    if (r == 7) return screen - int'($urandom_range(0, 3));
    return int'($urandom_range(0, 8191)) - 4096;
  endfunction

  task automatic send_item(fill_req_t rq);
    int gap;
    if (sender_gaps && burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= rq.op;
    s_tdata  <= InDataW'({rq.color, rq.rect_h, rq.rect_w, rq.corner_y, rq.corner_x});
    do @(posedge clk); while (!s_tready);
    pending_writes.push_back(advance_engine(rq));
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_start(int x, int y, int w, int h, int color);
    fill_req_t rq;
    rq.op       = OpStart;
    rq.corner_x = CoordW'(x);
    rq.corner_y = CoordW'(y);
    rq.rect_w   = DimW'(w);
    rq.rect_h   = DimW'(h);
    rq.color    = ColorW'(color);
    send_item(rq);
  endtask

  // other fields carry junk, the block must ignore them
  task automatic send_tick();
    fill_req_t rq;
    rq.op       = OpTick;
    rq.corner_x = CoordW'($urandom);
    rq.corner_y = CoordW'($urandom);
    rq.rect_w   = DimW'($urandom);
    rq.rect_h   = DimW'($urandom);
    rq.color    = ColorW'($urandom);
    send_item(rq);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, int value);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= CfgDataW'(value);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CfgScreenCols: regs.screen_columns = ScreenW'(value);
      CfgScreenRows: regs.screen_rows    = ScreenW'(value);
      CfgLineBytes:  regs.line_bytes     = LineW'(value);
      CfgPixelBits:  regs.pixel_bits     = PixBitsW'(value);
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_screen(cfg_t s);
    settle();
    write_reg(CfgScreenCols, s.screen_columns);
    write_reg(CfgScreenRows, s.screen_rows);
    write_reg(CfgLineBytes, s.line_bytes);
    write_reg(CfgPixelBits, s.pixel_bits);
  endtask

  task automatic pick_idling();
    sender_gaps = $urandom_range(0, 1);
    rx_style    = rx_style_e'($urandom_range(0, 2));
    rx_pattern  = 16'($urandom) | 16'h0101;
  endtask

  // mostly complete rectangles, some cut short or overrun, a few stray ticks
  task automatic run_fill_traffic(int n_items);
    int sent, w, h, ticks;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 11) == 0) begin
        send_tick();
        sent++;
      end else begin
        w = pick_size();
        h = pick_size();
        send_start(pick_corner(regs.screen_columns), pick_corner(regs.screen_rows), w, h,
                   $urandom_range(0, 65535));
        sent++;
        if (!eng_busy) ticks = $urandom_range(0, 2);
        else if (w * h <= 48) ticks = w * h + (($urandom_range(0, 3) == 0) ? 2 : 0);
        else ticks = $urandom_range(1, 40);
        if ($urandom_range(0, 7) == 0) ticks = $urandom_range(0, ticks);
        repeat (ticks) send_tick();
        sent += ticks;
      end
    end
  endtask

  task automatic test_directed_cases();
    sender_gaps = 1'b0;
    rx_style    = RxAlways;
    send_tick();                                  // idle tick
    send_start(-4096, -1, 3, 2, 16'hffff);        // negative corner clamps to zero
    repeat (7) send_tick();
    send_start(4095, 4095, 2, 2, 16'h0000);       // overrun shifts the corner back
    repeat (4) send_tick();
    send_start(0, 0, 4096, 1, 16'h1234);          // too wide, rejected
    send_tick();
    send_start(10, 20, 0, 5, 16'h4321);           // empty
    send_tick();
    send_start(100, 50, 5, 5, 16'ha5a5);
    repeat (2) send_tick();
    send_start(-1, 3, 1, 1, 16'h5a5a);            // restart while busy
    repeat (2) send_tick();
    send_start(0, 0, 1, 4096, 16'h0f0f);          // too tall, rejected
  endtask

  task automatic test_register_extremes();
    cfg_t corners[4];
    corners[0] = '{screen_columns: 4096, screen_rows: 4096, line_bytes: 16384, pixel_bits: 32};
    corners[1] = '{screen_columns: 1, screen_rows: 1, line_bytes: 1, pixel_bits: 8};
    corners[2] = '{screen_columns: 4095, screen_rows: 4095, line_bytes: 16383, pixel_bits: 31};
    corners[3] = '{screen_columns: 640, screen_rows: 480, line_bytes: 1280, pixel_bits: 16};
    for (int i = 0; i < 4; i++) begin
      load_screen(corners[i]);
      if (i == 0) begin
        sender_gaps = 1'b0;
        rx_style    = RxAlways;
      end else begin
        pick_idling();
      end
      run_fill_traffic(250);
    end
  endtask

  task automatic test_random_settings();
    cfg_t s;
    repeat (2) begin
      s.screen_columns = ScreenW'($urandom_range(1, 4096));
      s.screen_rows    = ScreenW'($urandom_range(1, 4096));
      s.line_bytes     = LineW'($urandom_range(1, 16384));
      s.pixel_bits     = PixBitsW'($urandom_range(8, 32));
      load_screen(s);
      pick_idling();
      run_fill_traffic(250);
    end
  endtask

  task automatic test_output_backpressure();
    settle();
    sender_gaps = 1'b0;
    rx_style    = RxAlways;
    rx_hold     = 400;
    run_fill_traffic(120);
  endtask

  task automatic check_write();
    pixel_write_t got, want;
    got.pix_valid = m_tuser[0];
    got.rejected  = m_tuser[1];
    got.offset    = m_tdata[OffW-1:0];
    got.color     = m_tdata[OffW +: ColorW];
    got.last      = m_tlast;
    if (pending_writes.size() == 0) begin
      errors++;
      if (errors <= MaxReports) $display("%0t: output transfer with nothing pending", $realtime);
    end else begin
      want = pending_writes.pop_front();
      if (got.pix_valid !== want.pix_valid || got.offset !== want.offset ||
          got.color !== want.color || got.last !== want.last ||
          got.rejected !== want.rejected) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: expected valid=%0b off=%h color=%h last=%0b rej=%0b, %s%0b %s%h %s%h %s%0b %s%0b",
                   $realtime, want.pix_valid, want.offset, want.color, want.last,
                   want.rejected, "got valid=", got.pix_valid, "off=", got.offset,
                   "color=", got.color, "last=", got.last, "rej=", got.rejected);
      end
    end
  endtask

  initial forever begin
    @(posedge clk);
    if (m_tvalid && m_tready) check_write();
    if (rx_hold > 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else begin
      case (rx_style)
        RxAlways: m_tready <= 1'b1;
        RxRandom: m_tready <= ($urandom_range(0, 9) < 7);
        default: begin
          rx_pattern = {rx_pattern[14:0], rx_pattern[15]};
          m_tready <= rx_pattern[0];
        end
      endcase
    end
  end

  initial forever begin
    @(posedge clk);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_register_extremes();
    test_random_settings();
    test_output_backpressure();
    settle();
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
